FILE: hw/rtl/tar_pkg.sv
`timescale 1ns / 1ps
// Shared types and widths for the tetrahedron aspect ratio tracker.
// No dependencies; every other file of the block depends on this package.
package tar_pkg;

    localparam int VERTS_PER_ELEMENT = 4;
    localparam int NUM_DIMS          = 3;
    localparam int COORD_W           = 32;
    localparam int RATIO_W           = 32;

    // Exact integer widths of the intermediate terms
    localparam int DIFF_W  = COORD_W + 1;          // coordinate difference
    localparam int L2_W    = 2 * COORD_W + 2;      // squared edge length
    localparam int C_W     = 2 * COORD_W + 2;      // cross product component, signed
    localparam int VV_W    = 2 * C_W;              // squared cross product norm
    localparam int DET_W   = C_W + COORD_W + 1;    // |six times volume|
    localparam int MP_W    = C_W + 2;              // multiplier operand, signed
    localparam int ACC_W   = VV_W + L2_W + 6;      // accumulator, signed
    localparam int ROOT_W  = 115;                  // square root result
    localparam int RAD_W   = 2 * ROOT_W;           // radicand
    localparam int PROD_W  = RAD_W - RATIO_W;      // bits of L2 * VV kept
    localparam int DIV_W   = DET_W + RATIO_W;      // divider working width
    localparam int STEP_W  = 7;                    // holds ROOT_W steps
    localparam int Q_DEPTH = 2;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
        logic                      mesh_end;
    } vertex_t;

    typedef struct packed {
        logic [RATIO_W-1:0] element_ratio;
        logic [RATIO_W-1:0] max_ratio;
        logic [RATIO_W-1:0] min_ratio;
        logic               degenerate;
        logic               final_element;
    } result_t;

    typedef enum logic {
        CMD_ELEMENT,
        CMD_CLEAR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                                      kind;
        logic                                           mesh_end;
        logic [VERTS_PER_ELEMENT-1:0][NUM_DIMS-1:0][COORD_W-1:0] p;
    } element_t;

    typedef struct packed {
        logic start;
        logic clr;
        logic sub;
    } mac_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_CHECK,
        ST_SQRT,
        ST_DIV_INIT,
        ST_DIV,
        ST_OUT
    } back_state_t;

    typedef enum logic [2:0] {
        PH_EDGE,
        PH_CROSS,
        PH_NORM,
        PH_DET,
        PH_PROD
    } phase_t;

endpackage

FILE: hw/rtl/tet_aspect_ratio_tracker.sv
`timescale 1ns / 1ps
// Top level of the tetrahedron aspect ratio tracker.
// Depends on tar_pkg, tar_front, tar_queue and tar_back.

// Vertices enter as signed Q16.16 x, y, z through a push/full port, one per
// cycle while the two-entry element queue has room; every fourth vertex
// completes an element and yields one result (ratio, mesh maximum and
// minimum, degenerate flag, mesh-end copy) on an empty/pop port backed by a
// one-item output register. A mesh end on a partial element drops it and
// clears the extrema without a result. All arithmetic is exact: the back end
// works through one element at a time on a bit-serial multiply-accumulate
// unit (58 operations) followed by a 115-step square root and a 32-step
// divide.
module tet_aspect_ratio_tracker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  tar_pkg::vertex_t vertex,
    input  logic             pop,
    output logic             empty,
    output tar_pkg::result_t result
);
    import tar_pkg::*;

    logic     q_full;
    logic     q_push;
    element_t q_wdata;
    logic     q_pop;
    element_t q_rdata;
    logic     q_empty;

    tar_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .vertex (vertex),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_wdata)
    );

    tar_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    tar_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_rdata),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule

FILE: hw/rtl/tar_front.sv
`timescale 1ns / 1ps
// Front end: collects vertices and hands complete elements or mesh-end
// clear commands to the element queue. Depends on tar_pkg.
module tar_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  tar_pkg::vertex_t  vertex,
    input  logic              q_full,
    output logic              q_push,
    output tar_pkg::element_t q_data
);
    import tar_pkg::*;

    logic [1:0] count_reg;
    logic [1:0] count_next;
    coord_t     store_reg [VERTS_PER_ELEMENT-1][NUM_DIMS];
    logic       accept;
    logic       last;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign last   = (count_reg == 2'(VERTS_PER_ELEMENT - 1));
    assign q_push = accept && (last || vertex.mesh_end);

    always_comb
    begin
        q_data.kind     = last ? CMD_ELEMENT : CMD_CLEAR;
        q_data.mesh_end = vertex.mesh_end;
        for (int i = 0; i < VERTS_PER_ELEMENT - 1; i++)
        begin
            for (int d = 0; d < NUM_DIMS; d++)
            begin
                q_data.p[i][d] = store_reg[i][d];
            end
        end
        q_data.p[VERTS_PER_ELEMENT-1][0] = vertex.coord_x;
        q_data.p[VERTS_PER_ELEMENT-1][1] = vertex.coord_y;
        q_data.p[VERTS_PER_ELEMENT-1][2] = vertex.coord_z;
    end

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            // drop a partial element at mesh end
            if (last || vertex.mesh_end)
                count_next = '0;
            else
                count_next = count_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept && !last)
        begin
            store_reg[count_reg][0] <= vertex.coord_x;
            store_reg[count_reg][1] <= vertex.coord_y;
            store_reg[count_reg][2] <= vertex.coord_z;
        end
    end

endmodule

FILE: hw/rtl/tar_queue.sv
`timescale 1ns / 1ps
// Short element queue between the front and back ends.
// Depends on tar_pkg for the entry type and depth.
module tar_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tar_pkg::element_t wdata,
    output logic              full,
    input  logic              pop,
    output tar_pkg::element_t rdata,
    output logic              empty
);
    import tar_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    element_t         entry_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == CNT_W'(Q_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= wdata;
    end

endmodule

FILE: hw/rtl/tar_mac.sv
`timescale 1ns / 1ps
// Bit-serial signed multiply-accumulate unit: acc +/-= mcand * mplier,
// one multiplier bit per cycle. Depends on tar_pkg.
module tar_mac (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tar_pkg::mac_cmd_t                   cmd,
    input  logic signed [tar_pkg::ACC_W-1:0]    mcand,
    input  logic signed [tar_pkg::MP_W-1:0]     mplier,
    output logic signed [tar_pkg::ACC_W-1:0]    acc,
    output logic                                busy
);
    import tar_pkg::*;

    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [ACC_W-1:0] mc_reg, mc_next;
    logic [MP_W-1:0]         mag_reg, mag_next;
    logic                    sub_reg, sub_next;
    logic signed [ACC_W-1:0] addend;
    logic                    neg;

    assign acc    = acc_reg;
    assign busy   = (mag_reg != '0);
    assign neg    = mplier[MP_W-1];
    assign addend = mag_reg[0] ? mc_reg : '0;

    always_comb
    begin
        acc_next = acc_reg;
        mc_next  = mc_reg;
        mag_next = mag_reg;
        sub_next = sub_reg;
        if (cmd.start)
        begin
            // fold the multiplier sign into the add/subtract choice
            mag_next = neg ? $unsigned(-mplier) : $unsigned(mplier);
            sub_next = cmd.sub ^ neg;
            mc_next  = mcand;
            if (cmd.clr)
                acc_next = '0;
        end
        else if (busy)
        begin
            acc_next = sub_reg ? acc_reg - addend : acc_reg + addend;
            mc_next  = mc_reg <<< 1;
            mag_next = mag_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mag_reg <= '0;
        else
            mag_reg <= mag_next;
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        sub_reg <= sub_next;
    end

endmodule

FILE: hw/rtl/tar_back.sv
`timescale 1ns / 1ps
// Back end: sequences the edge, cross product, volume, square root and
// division work for one element and keeps the mesh extrema. Depends on
// tar_pkg and tar_mac.
module tar_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  tar_pkg::element_t q_data,
    output logic              q_pop,
    input  logic              pop,
    output logic              empty,
    output tar_pkg::result_t  result
);
    import tar_pkg::*;

    back_state_t        state_reg, state_next;
    phase_t             phase_reg, phase_next;
    element_t           elem_reg, elem_next;
    logic [2:0]         e_reg, e_next;
    logic [1:0]         d_reg, d_next;
    logic [1:0]         f_reg, f_next;
    logic [1:0]         k_reg, k_next;
    logic               t_reg, t_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [L2_W-1:0]    l2_reg, l2_next;
    logic [VV_W-1:0]    vv_reg, vv_next;
    logic signed [C_W-1:0] c_reg [NUM_DIMS];
    logic signed [C_W-1:0] c_next [NUM_DIMS];
    logic [DET_W-1:0]   det_reg, det_next;
    logic [RAD_W-1:0]   rad_reg, rad_next;
    logic [ROOT_W-1:0]  root_reg, root_next;
    logic [ROOT_W:0]    srem_reg, srem_next;
    logic [DIV_W-1:0]   drem_reg, drem_next;
    logic [DIV_W-1:0]   dsh_reg, dsh_next;
    logic [RATIO_W-1:0] q_reg, q_next;
    logic [RATIO_W-1:0] ratio_reg, ratio_next;
    logic               degen_reg, degen_next;
    logic [RATIO_W-1:0] max_reg, max_next;
    logic [RATIO_W-1:0] min_reg, min_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg, out_next;

    mac_cmd_t                mac_cmd;
    logic signed [ACC_W-1:0] mcand;
    logic signed [MP_W-1:0]  mplier;
    logic signed [ACC_W-1:0] acc;
    logic                    mac_busy;
    logic [ACC_W-1:0]        acc_abs;

    logic [1:0]              ea, eb, fb, fc, k1, k2;
    logic signed [DIFF_W-1:0] edge_d, u_t0, v_t0, u_t1, v_t1, det_d;

    logic [ROOT_W+2:0]       rem2, trial, sq_diff;
    logic                    sq_ge;
    logic [DIV_W-1:0]        div_diff;
    logic                    div_ge;
    logic [RATIO_W-1:0]      q_step;
    logic [RATIO_W-1:0]      new_max, new_min;

    function automatic logic signed [DIFF_W-1:0] dif(input coord_t a, input coord_t b);
        dif = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
    endfunction

    function automatic coord_t pc(input element_t el, input logic [1:0] v,
                                  input logic [1:0] dm);
        pc = el.p[v][dm];
    endfunction

    function automatic logic [1:0] next_dim(input logic [1:0] k);
        next_dim = (k == 2'd2) ? 2'd0 : k + 2'd1;
    endfunction

    // vertex pairs of the tetrahedron's edges
    function automatic logic [1:0] edge_a(input logic [2:0] e);
        unique case (e)
            3'd0, 3'd1, 3'd2: edge_a = 2'd0;
            3'd3, 3'd4:       edge_a = 2'd1;
            default:          edge_a = 2'd2;
        endcase
    endfunction

    function automatic logic [1:0] edge_b(input logic [2:0] e);
        unique case (e)
            3'd0:       edge_b = 2'd1;
            3'd1, 3'd3: edge_b = 2'd2;
            default:    edge_b = 2'd3;
        endcase
    endfunction

    tar_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (mac_cmd),
        .mcand  (mcand),
        .mplier (mplier),
        .acc    (acc),
        .busy   (mac_busy)
    );

    assign acc_abs = acc[ACC_W-1] ? $unsigned(-acc) : $unsigned(acc);
    assign empty   = !out_valid_reg;
    assign result  = out_reg;

    // operand selection for the multiply-accumulate unit
    always_comb
    begin
        ea     = edge_a(e_reg);
        eb     = edge_b(e_reg);
        fb     = f_reg + 2'd1;
        fc     = f_reg + 2'd2;
        k1     = next_dim(k_reg);
        k2     = next_dim(k1);
        edge_d = dif(pc(elem_reg, ea, d_reg), pc(elem_reg, eb, d_reg));
        u_t0   = dif(pc(elem_reg, fb, k1), pc(elem_reg, f_reg, k1));
        v_t0   = dif(pc(elem_reg, fc, k2), pc(elem_reg, f_reg, k2));
        u_t1   = dif(pc(elem_reg, fb, k2), pc(elem_reg, f_reg, k2));
        v_t1   = dif(pc(elem_reg, fc, k1), pc(elem_reg, f_reg, k1));
        det_d  = dif(pc(elem_reg, 2'd0, k_reg), pc(elem_reg, 2'd3, k_reg));

        mac_cmd.start = (state_reg == ST_ISSUE);
        mac_cmd.clr   = 1'b0;
        mac_cmd.sub   = 1'b0;
        unique case (phase_reg)
            PH_EDGE:
            begin
                mcand       = ACC_W'(edge_d);
                mplier      = MP_W'(edge_d);
                mac_cmd.clr = (d_reg == 2'd0);
            end
            PH_CROSS:
            begin
                mcand       = t_reg ? ACC_W'(u_t1) : ACC_W'(u_t0);
                mplier      = t_reg ? MP_W'(v_t1) : MP_W'(v_t0);
                mac_cmd.clr = !t_reg;
                mac_cmd.sub = t_reg;
            end
            PH_NORM:
            begin
                mcand       = ACC_W'(c_reg[k_reg]);
                mplier      = MP_W'(c_reg[k_reg]);
                mac_cmd.clr = (k_reg == 2'd0);
            end
            PH_DET:
            begin
                mcand       = ACC_W'(c_reg[k_reg]);
                mplier      = MP_W'(det_d);
                mac_cmd.clr = (k_reg == 2'd0);
            end
            default:
            begin
                mcand       = $signed(ACC_W'(vv_reg));
                mplier      = $signed(MP_W'(l2_reg));
                mac_cmd.clr = 1'b1;
            end
        endcase
    end

    // square root and division steps
    always_comb
    begin
        rem2     = {srem_reg, rad_reg[RAD_W-1 -: 2]};
        trial    = {1'b0, root_reg, 2'b01};
        sq_ge    = (rem2 >= trial);
        sq_diff  = rem2 - trial;
        div_ge   = (dsh_reg <= drem_reg);
        div_diff = drem_reg - dsh_reg;
        q_step   = {q_reg[RATIO_W-2:0], div_ge};
        new_max  = (ratio_reg > max_reg) ? ratio_reg : max_reg;
        new_min  = (ratio_reg < min_reg) ? ratio_reg : min_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        elem_next      = elem_reg;
        e_next         = e_reg;
        d_next         = d_reg;
        f_next         = f_reg;
        k_next         = k_reg;
        t_next         = t_reg;
        step_next      = step_reg;
        l2_next        = l2_reg;
        vv_next        = vv_reg;
        c_next         = c_reg;
        det_next       = det_reg;
        rad_next       = rad_reg;
        root_next      = root_reg;
        srem_next      = srem_reg;
        drem_next      = drem_reg;
        dsh_next       = dsh_reg;
        q_next         = q_reg;
        ratio_next     = ratio_reg;
        degen_next     = degen_reg;
        max_next       = max_reg;
        min_next       = min_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        q_pop          = 1'b0;

        if (pop && out_valid_reg)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (q_data.kind == CMD_CLEAR)
                    begin
                        max_next = '0;
                        min_next = '1;
                    end
                    else
                    begin
                        elem_next  = q_data;
                        phase_next = PH_EDGE;
                        e_next     = '0;
                        d_next     = '0;
                        f_next     = '0;
                        k_next     = '0;
                        t_next     = 1'b0;
                        l2_next    = '0;
                        vv_next    = '0;
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_ISSUE:
                state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (!mac_busy)
                begin
                    state_next = ST_ISSUE;
                    unique case (phase_reg)
                        PH_EDGE:
                        begin
                            if (d_reg == 2'd2)
                            begin
                                if (acc[L2_W-1:0] > l2_reg)
                                    l2_next = acc[L2_W-1:0];
                                d_next = '0;
                                if (e_reg == 3'd5)
                                    phase_next = PH_CROSS;
                                else
                                    e_next = e_reg + 3'd1;
                            end
                            else
                                d_next = d_reg + 2'd1;
                        end
                        PH_CROSS:
                        begin
                            t_next = !t_reg;
                            if (t_reg)
                            begin
                                c_next[k_reg] = acc[C_W-1:0];
                                if (k_reg == 2'd2)
                                begin
                                    k_next     = '0;
                                    phase_next = PH_NORM;
                                end
                                else
                                    k_next = k_reg + 2'd1;
                            end
                        end
                        PH_NORM:
                        begin
                            if (k_reg == 2'd2)
                            begin
                                if (acc[VV_W-1:0] > vv_reg)
                                    vv_next = acc[VV_W-1:0];
                                k_next = '0;
                                // volume only from the first face
                                if (f_reg == 2'd0)
                                    phase_next = PH_DET;
                                else if (f_reg == 2'd3)
                                    phase_next = PH_PROD;
                                else
                                begin
                                    f_next     = f_reg + 2'd1;
                                    phase_next = PH_CROSS;
                                end
                            end
                            else
                                k_next = k_reg + 2'd1;
                        end
                        PH_DET:
                        begin
                            if (k_reg == 2'd2)
                            begin
                                det_next   = acc_abs[DET_W-1:0];
                                k_next     = '0;
                                f_next     = f_reg + 2'd1;
                                phase_next = PH_CROSS;
                            end
                            else
                                k_next = k_reg + 2'd1;
                        end
                        default:
                            state_next = ST_CHECK;
                    endcase
                end
            end
            ST_CHECK:
            begin
                if (det_reg == '0)
                begin
                    ratio_next = '1;
                    degen_next = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    rad_next   = {acc[PROD_W-1:0], {RATIO_W{1'b0}}};
                    root_next  = '0;
                    srem_next  = '0;
                    step_next  = STEP_W'(ROOT_W);
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                rad_next  = rad_reg << 2;
                root_next = {root_reg[ROOT_W-2:0], sq_ge};
                srem_next = sq_ge ? sq_diff[ROOT_W:0] : rem2[ROOT_W:0];
                step_next = step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                    state_next = ST_DIV_INIT;
            end
            ST_DIV_INIT:
            begin
                // saturate when the quotient would not fit the ratio
                if (DIV_W'(root_reg) >= {det_reg, {RATIO_W{1'b0}}})
                begin
                    ratio_next = '1;
                    degen_next = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    drem_next  = DIV_W'(root_reg);
                    dsh_next   = {1'b0, det_reg, {(RATIO_W - 1){1'b0}}};
                    q_next     = '0;
                    step_next  = STEP_W'(RATIO_W);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_ge)
                    drem_next = div_diff;
                q_next    = q_step;
                dsh_next  = dsh_reg >> 1;
                step_next = step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    ratio_next = q_step;
                    degen_next = 1'b0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // hold until the result register is free
                if (!out_valid_reg)
                begin
                    out_next.element_ratio = ratio_reg;
                    out_next.max_ratio     = new_max;
                    out_next.min_ratio     = new_min;
                    out_next.degenerate    = degen_reg;
                    out_next.final_element = elem_reg.mesh_end;
                    out_valid_next         = 1'b1;
                    if (elem_reg.mesh_end)
                    begin
                        max_next = '0;
                        min_next = '1;
                    end
                    else
                    begin
                        max_next = new_max;
                        min_next = new_min;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_EDGE;
            e_reg         <= '0;
            d_reg         <= '0;
            f_reg         <= '0;
            k_reg         <= '0;
            t_reg         <= 1'b0;
            step_reg      <= '0;
            max_reg       <= '0;
            min_reg       <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            e_reg         <= e_next;
            d_reg         <= d_next;
            f_reg         <= f_next;
            k_reg         <= k_next;
            t_reg         <= t_next;
            step_reg      <= step_next;
            max_reg       <= max_next;
            min_reg       <= min_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        elem_reg  <= elem_next;
        l2_reg    <= l2_next;
        vv_reg    <= vv_next;
        c_reg     <= c_next;
        det_reg   <= det_next;
        rad_reg   <= rad_next;
        root_reg  <= root_next;
        srem_reg  <= srem_next;
        drem_reg  <= drem_next;
        dsh_reg   <= dsh_next;
        q_reg     <= q_next;
        ratio_reg <= ratio_next;
        degen_reg <= degen_next;
        out_reg   <= out_next;
    end

endmodule

FILE: hw/rtl/tar_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the aspect ratio tracker, bound to the top level.
// Depends on tar_pkg and tet_aspect_ratio_tracker.
module tar_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             pop,
    input logic             empty,
    input tar_pkg::result_t result
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty)
        else $error("result withdrawn before it was taken");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> $stable(result))
        else $error("waiting result changed");

    a_extrema: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.min_ratio <= result.element_ratio) &&
                   (result.element_ratio <= result.max_ratio))
        else $error("extrema do not bracket the element ratio");

    a_degen_sat: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.degenerate |-> (result.element_ratio == '1))
        else $error("degenerate element without saturated ratio");

endmodule

bind tet_aspect_ratio_tracker tar_checker u_tar_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .pop    (pop),
    .empty  (empty),
    .result (result)
);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for tet_aspect_ratio_tracker: vertex items in, ratio items out.
// Depends on tar_pkg and the block's RTL; computes the expected ratios exactly in 256-bit integers.
module tb_top;
    import tar_pkg::*;

    typedef logic signed [255:0] wide_t;

    localparam longint CYCLE_LIMIT = 64'd40_000_000;
    localparam int     DRAIN_WAIT  = 4000;
    localparam int     RANDOM_ITEMS = 1400;

    logic    clk;
    logic    rst_n;
    logic    push;
    logic    full;
    vertex_t vertex;
    logic    pop;
    logic    empty;
    result_t result;

    tet_aspect_ratio_tracker dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .vertex (vertex),
        .pop    (pop),
        .empty  (empty),
        .result (result)
    );

    // predictor state
    coord_t      elem_pts[VERTS_PER_ELEMENT][NUM_DIMS];
    int unsigned vert_slot;
    logic [31:0] mesh_max;
    logic [31:0] mesh_min;
    result_t     ratios_due[$];

    int     send_idle_pct;
    int     recv_idle_pct;
    int     mismatches;
    int     stray_items;
    longint cycles;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    function automatic wide_t diff_of(input int a, input int b, input int d);
        wide_t wa;
        wide_t wb;
        wa = elem_pts[a][d];
        wb = elem_pts[b][d];
        return wa - wb;
    endfunction

    // Exact aspect ratio of the stored element: longest edge over least height.
    function automatic logic [31:0] aspect_ratio(output logic degen);
        wide_t edge_sq, longest_sq, norm_sq, widest_sq, vol6, rad, root, trial;
        wide_t u[3];
        wide_t v[3];
        wide_t cr[3];
        int nb, nc;
        edge_sq    = '0;
        longest_sq = '0;
        widest_sq  = '0;
        vol6       = '0;
        root       = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = i + 1; j < 4; j++)
            begin
                edge_sq = diff_of(i, j, 0) * diff_of(i, j, 0)
                        + diff_of(i, j, 1) * diff_of(i, j, 1)
                        + diff_of(i, j, 2) * diff_of(i, j, 2);
                if ($unsigned(edge_sq) > $unsigned(longest_sq))
                    longest_sq = edge_sq;
            end
        end
        for (int f = 0; f < 4; f++)
        begin
            nb = (f + 1) % 4;
            nc = (f + 2) % 4;
            for (int d = 0; d < 3; d++)
            begin
                u[d] = diff_of(nb, f, d);
                v[d] = diff_of(nc, f, d);
            end
            cr[0] = u[1] * v[2] - u[2] * v[1];
            cr[1] = u[2] * v[0] - u[0] * v[2];
            cr[2] = u[0] * v[1] - u[1] * v[0];
            norm_sq = cr[0] * cr[0] + cr[1] * cr[1] + cr[2] * cr[2];
            if ($unsigned(norm_sq) > $unsigned(widest_sq))
                widest_sq = norm_sq;
            if (f == 0)
                vol6 = cr[0] * diff_of(0, 3, 0) + cr[1] * diff_of(0, 3, 1)
                     + cr[2] * diff_of(0, 3, 2);
        end
        if (vol6 < 0)
            vol6 = -vol6;
        if (vol6 == 0)
        begin
            degen = 1'b1;
            return 32'hFFFF_FFFF;
        end
        rad = (longest_sq * widest_sq) <<< 32;
        for (int b = 127; b >= 0; b--)
        begin
            trial = root;
            trial[b] = 1'b1;
            if ($unsigned(trial * trial) <= $unsigned(rad))
                root = trial;
        end
        if ($unsigned(root) >= $unsigned(vol6 <<< 32))
        begin
            degen = 1'b1;
            return 32'hFFFF_FFFF;
        end
        degen = 1'b0;
        return 32'($unsigned(root) / $unsigned(vol6));
    endfunction

    // Advance the predictor by one accepted vertex.
    task automatic track_vertex(input vertex_t v);
        result_t r;
        logic    degen;
        elem_pts[vert_slot][0] = v.coord_x;
        elem_pts[vert_slot][1] = v.coord_y;
        elem_pts[vert_slot][2] = v.coord_z;
        if (vert_slot != 3)
        begin
            vert_slot = v.mesh_end ? 0 : vert_slot + 1;
            if (v.mesh_end)
            begin
                mesh_max = '0;
                mesh_min = '1;
            end
            return;
        end
        vert_slot = 0;
        r.element_ratio = aspect_ratio(degen);
        if (r.element_ratio > mesh_max)
            mesh_max = r.element_ratio;
        if (r.element_ratio < mesh_min)
            mesh_min = r.element_ratio;
        r.max_ratio     = mesh_max;
        r.min_ratio     = mesh_min;
        r.degenerate    = degen;
        r.final_element = v.mesh_end;
        ratios_due.push_back(r);
        if (v.mesh_end)
        begin
            mesh_max = '0;
            mesh_min = '1;
        end
    endtask

    // Result side: check each popped item, then roll the next pop.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (ratios_due.size() == 0)
            begin
                stray_items <= stray_items + 1;
                if (mismatches + stray_items < 10)
                    $display("unexpected result %h", result);
            end
            else
            begin
                if (result !== ratios_due[0])
                begin
                    if (mismatches < 10)
                        $display("mismatch: expected %h actual %h", ratios_due[0], result);
                    mismatches <= mismatches + 1;
                end
                void'(ratios_due.pop_front());
            end
        end
        pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_vertex(input coord_t x, input coord_t y, input coord_t z,
                               input logic last);
        vertex_t v;
        v.coord_x  = x;
        v.coord_y  = y;
        v.coord_z  = z;
        v.mesh_end = last;
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push   <= 1'b1;
        vertex <= v;
        do
            @(posedge clk);
        while (full);
        track_vertex(v);
    endtask

    task automatic send_tet(input coord_t p[4][3], input logic last);
        for (int i = 0; i < 4; i++)
            send_vertex(p[i][0], p[i][1], p[i][2], (i == 3) ? last : 1'b0);
    endtask

    task automatic hold_until_drained();
        push <= 1'b0;
        while (ratios_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_regular_and_extremes();
        coord_t p[4][3];
        coord_t lo, hi;
        lo = 32'sh8000_0000;
        hi = 32'sh7FFF_FFFF;
        p = '{'{0, 0, 0}, '{65536, 0, 0}, '{0, 65536, 0}, '{0, 0, 65536}};
        send_tet(p, 1'b0);
        p = '{'{lo, lo, lo}, '{hi, lo, lo}, '{lo, hi, lo}, '{lo, lo, hi}};
        send_tet(p, 1'b0);
        p = '{'{hi, hi, hi}, '{lo, hi, hi}, '{hi, lo, hi}, '{hi, hi, lo}};
        send_tet(p, 1'b1);
        p = '{'{-1, 0, 0}, '{0, -1, 0}, '{0, 0, -1}, '{1, 1, 1}};
        send_tet(p, 1'b0);
    endtask

    task automatic test_degenerate();
        coord_t p[4][3];
        // flat element
        p = '{'{0, 0, 0}, '{65536, 0, 0}, '{0, 65536, 0}, '{65536, 65536, 0}};
        send_tet(p, 1'b0);
        // coincident vertices
        p = '{'{7, 7, 7}, '{7, 7, 7}, '{7, 7, 7}, '{7, 7, 7}};
        send_tet(p, 1'b0);
        // needle: height of one unit under huge edges, ratio overflows
        p = '{'{0, 0, 0}, '{32'sh7FFF_FFFF, 0, 0}, '{0, 32'sh7FFF_FFFF, 0}, '{0, 0, 1}};
        send_tet(p, 1'b1);
    endtask

    task automatic test_partial_mesh_end();
        coord_t p[4][3];
        send_vertex(100, 200, 300, 1'b0);
        send_vertex(-5, 9, 1, 1'b1);
        send_vertex(3, 3, 3, 1'b1);
        p = '{'{0, 0, 0}, '{131072, 0, 0}, '{0, 65536, 0}, '{0, 0, 65536}};
        send_tet(p, 1'b0);
        send_vertex(1, 2, 3, 1'b0);
        send_vertex(4, 5, 6, 1'b0);
        send_vertex(7, 8, 9, 1'b1);
    endtask

    function automatic coord_t rand_offset(input int span);
        return coord_t'(int'($urandom_range(2 * span)) - span);
    endfunction

    task automatic test_random_mesh(input int n_items);
        coord_t p[4][3];
        coord_t base;
        int span, sent, kind;
        sent = 0;
        while (sent < n_items)
        begin
            kind = $urandom_range(99);
            if (kind < 6)
            begin
                // broken element: a mesh end part way through
                send_vertex($urandom, $urandom, $urandom, 1'b1);
                sent++;
                continue;
            end
            span = (kind < 12) ? 1 : (kind < 20) ? 1 << 30 : 1 << $urandom_range(4, 20);
            for (int d = 0; d < 3; d++)
            begin
                base = $urandom;
                for (int i = 0; i < 4; i++)
                    p[i][d] = (kind < 20 && kind >= 12) ? coord_t'($urandom)
                                                      : base + rand_offset(span);
            end
            if (kind >= 20 && kind < 26)
                p[3] = p[$urandom_range(2)];
            send_tet(p, ($urandom_range(9) == 0));
            sent += 4;
        end
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        push          = 1'b0;
        pop           = 1'b0;
        vertex        = '0;
        cycles        = 0;
        mismatches    = 0;
        stray_items   = 0;
        vert_slot     = 0;
        mesh_max      = '0;
        mesh_min      = '1;
        send_idle_pct = 30;
        recv_idle_pct = 82;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_regular_and_extremes();
        test_degenerate();
        hold_until_drained();
        test_partial_mesh_end();
        test_random_mesh(RANDOM_ITEMS / 3);

        send_idle_pct = 82;
        recv_idle_pct = 30;
        test_random_mesh(RANDOM_ITEMS / 3);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_mesh(RANDOM_ITEMS / 3);

        hold_until_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0 && stray_items == 0 && ratios_due.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
